FILE: rtl/vending_sale_and_change_macros.svh
// vending_sale_and_change_macros.svh: assertion macros for the vending block
// used by the top level; expects clk_i and rst_ni in the including scope
`ifndef VENDING_SALE_AND_CHANGE_MACROS_SVH
`define VENDING_SALE_AND_CHANGE_MACROS_SVH

// same-cycle implication
`define VSC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("vsc: same-cycle check failed");

// next-cycle implication
`define VSC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("vsc: next-cycle check failed");

`endif

FILE: rtl/vsc_pkg.sv
// vsc_pkg: types, codes and constants of the vending sale and change block
// no dependencies
`default_nettype none

package vsc_pkg;

  typedef enum logic [0:0] {
    CMD_ADD = 1'b0,
    CMD_BUY = 1'b1
  } command_e;

  typedef enum logic [2:0] {
    ST_ADDED      = 3'd0,
    ST_DUPLICATE  = 3'd1,
    ST_FULL       = 3'd2,
    ST_NOT_FOUND  = 3'd3,
    ST_TOO_LITTLE = 3'd4,
    ST_PAID       = 3'd5,
    ST_PARTIAL    = 3'd6
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEARCH,
    S_DECIDE,
    S_BANK10,
    S_BANK5,
    S_BANK1,
    S_PAY10,
    S_PAY5,
    S_PAY1,
    S_OUT
  } state_e;

  typedef enum logic [0:0] {
    MODE_BANK = 1'b0,
    MODE_PAY  = 1'b1
  } coin_mode_e;

  typedef enum logic [1:0] {
    DEN_10 = 2'd0,
    DEN_5  = 2'd1,
    DEN_1  = 2'd2
  } denom_e;

  localparam int unsigned CODE_W  = 16;
  localparam int unsigned PRICE_W = 10;
  localparam int unsigned MONEY_W = 10;
  localparam int unsigned COIN_W  = 16;

  // x / 10 = (x * 205) >> 11 and x / 5 = (x * 205) >> 10, exact for x < 1024
  localparam logic [7:0] RECIP   = 8'd205;
  localparam int unsigned PROD_W = MONEY_W + 8;

  typedef struct packed {
    command_e              command;
    logic [CODE_W-1:0]     product_code;
    logic [PRICE_W-1:0]    price;
    logic [MONEY_W-1:0]    money;
  } in_t;

  typedef struct packed {
    status_e               status;
    logic [MONEY_W-1:0]    change_paid;
    logic [MONEY_W-1:0]    change_unpaid;
    logic [COIN_W-1:0]     tens_held;
    logic [COIN_W-1:0]     fives_held;
    logic [COIN_W-1:0]     ones_held;
  } out_t;

  typedef struct packed {
    coin_mode_e mode;
    denom_e     denom;
  } coin_op_t;

endpackage

`default_nettype wire

FILE: rtl/vending_sale_and_change.sv
// vending_sale_and_change: product table and coin store of a vending machine
// depends on vsc_pkg, vsc_coin_unit and vending_sale_and_change_macros.svh
`default_nettype none

// channel  direction  handshake               payload
// in       sink       in_valid_i / in_ready_o  in_i  (vsc_pkg::in_t)
// out      source     out_valid_o / out_ready_i out_o (vsc_pkg::out_t)
//
// one transaction at a time; in_ready_o is high only while idle
// table walk: one read of the product memory per cycle, first hit stops it;
//   a miss reads every stored entry before the decide step
// add: search and a decide step; buy: search, a decide step and, when the sale goes through, 6 coin unit steps
// the result is then held in registers until out_ready_i
// asynchronous active-low reset empties the table and zeroes the coin counts

module vending_sale_and_change #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  vsc_pkg::in_t   in_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output vsc_pkg::out_t  out_o
);
  import vsc_pkg::*;

`include "vending_sale_and_change_macros.svh"

  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned MEM_W = CODE_W + PRICE_W;

  // control state
  state_e             state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [CNT_W-1:0]   idx_q, idx_d;
  logic               chk_q, chk_d;
  logic               found_q, found_d;
  logic [COIN_W-1:0]  tens_q, tens_d;
  logic [COIN_W-1:0]  fives_q, fives_d;
  logic [COIN_W-1:0]  ones_q, ones_d;

  // payload state
  in_t                item_q, item_d;
  logic [PRICE_W-1:0] price_q, price_d;
  logic [MONEY_W-1:0] amt_q, amt_d;
  logic [MONEY_W-1:0] diff_q, diff_d;
  status_e            status_q, status_d;
  logic [MONEY_W-1:0] paid_q, paid_d;
  logic [MONEY_W-1:0] unpaid_q, unpaid_d;

  // product memory, one code and price per word
  logic [MEM_W-1:0]   mem_q [TABLE_DEPTH];
  logic [MEM_W-1:0]   rd_q;
  logic               rd_en;
  logic               wr_en;
  logic [CODE_W-1:0]  rd_code;
  logic [PRICE_W-1:0] rd_price;

  // shared coin unit
  coin_op_t           op;
  logic [COIN_W-1:0]  coin_cnt;
  logic [MONEY_W-1:0] unit_amt;
  logic [COIN_W-1:0]  unit_cnt;

  assign rd_code  = rd_q[MEM_W-1:PRICE_W];
  assign rd_price = rd_q[PRICE_W-1:0];

  always_comb begin
    case (op.denom)
      DEN_10:  coin_cnt = tens_q;
      DEN_5:   coin_cnt = fives_q;
      DEN_1:   coin_cnt = ones_q;
      default: coin_cnt = ones_q;
    endcase
  end

  vsc_coin_unit u_coin (
    .op_i     (op),
    .amount_i (amt_q),
    .count_i  (coin_cnt),
    .amount_o (unit_amt),
    .count_o  (unit_cnt)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  assign out_o.status        = status_q;
  assign out_o.change_paid   = paid_q;
  assign out_o.change_unpaid = unpaid_q;
  assign out_o.tens_held     = tens_q;
  assign out_o.fives_held    = fives_q;
  assign out_o.ones_held     = ones_q;

  // sequencer
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    idx_d    = idx_q;
    chk_d    = 1'b0;
    found_d  = found_q;
    tens_d   = tens_q;
    fives_d  = fives_q;
    ones_d   = ones_q;
    item_d   = item_q;
    price_d  = price_q;
    amt_d    = amt_q;
    diff_d   = diff_q;
    status_d = status_q;
    paid_d   = paid_q;
    unpaid_d = unpaid_q;
    rd_en    = 1'b0;
    wr_en    = 1'b0;
    op       = '{mode: MODE_BANK, denom: DEN_1};

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_i;
          idx_d   = '0;
          found_d = 1'b0;
          state_d = S_SEARCH;
        end
      end

      S_SEARCH: begin
        // compare the word read last cycle while the next read goes out
        if (chk_q && (rd_code == item_q.product_code)) begin
          found_d = 1'b1;
          price_d = rd_price;
          state_d = S_DECIDE;
        end else if (idx_q != cnt_q) begin
          rd_en = 1'b1;
          chk_d = 1'b1;
          idx_d = idx_q + CNT_W'(1);
        end else begin
          state_d = S_DECIDE;
        end
      end

      S_DECIDE: begin
        paid_d   = '0;
        unpaid_d = '0;
        state_d  = S_OUT;
        if (item_q.command == CMD_ADD) begin
          if (found_q) begin
            status_d = ST_DUPLICATE;
          end else if (cnt_q == CNT_W'(TABLE_DEPTH)) begin
            status_d = ST_FULL;
          end else begin
            wr_en    = 1'b1;
            cnt_d    = cnt_q + CNT_W'(1);
            status_d = ST_ADDED;
          end
        end else if (!found_q) begin
          status_d = ST_NOT_FOUND;
        end else if (item_q.money < price_q) begin
          status_d = ST_TOO_LITTLE;
        end else begin
          amt_d   = item_q.money;
          diff_d  = item_q.money - price_q;
          state_d = S_BANK10;
        end
      end

      S_BANK10: begin
        op      = '{mode: MODE_BANK, denom: DEN_10};
        tens_d  = unit_cnt;
        amt_d   = unit_amt;
        state_d = S_BANK5;
      end

      S_BANK5: begin
        op      = '{mode: MODE_BANK, denom: DEN_5};
        fives_d = unit_cnt;
        amt_d   = unit_amt;
        state_d = S_BANK1;
      end

      S_BANK1: begin
        // sum fully banked, start paying out the change
        op      = '{mode: MODE_BANK, denom: DEN_1};
        ones_d  = unit_cnt;
        amt_d   = diff_q;
        state_d = S_PAY10;
      end

      S_PAY10: begin
        op      = '{mode: MODE_PAY, denom: DEN_10};
        tens_d  = unit_cnt;
        amt_d   = unit_amt;
        state_d = S_PAY5;
      end

      S_PAY5: begin
        op      = '{mode: MODE_PAY, denom: DEN_5};
        fives_d = unit_cnt;
        amt_d   = unit_amt;
        state_d = S_PAY1;
      end

      S_PAY1: begin
        op       = '{mode: MODE_PAY, denom: DEN_1};
        ones_d   = unit_cnt;
        amt_d    = unit_amt;
        paid_d   = diff_q - unit_amt;
        unpaid_d = unit_amt;
        status_d = (unit_amt == '0) ? ST_PAID : ST_PARTIAL;
        state_d  = S_OUT;
      end

      S_OUT: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      idx_q   <= '0;
      chk_q   <= 1'b0;
      found_q <= 1'b0;
      tens_q  <= '0;
      fives_q <= '0;
      ones_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      chk_q   <= chk_d;
      found_q <= found_d;
      tens_q  <= tens_d;
      fives_q <= fives_d;
      ones_q  <= ones_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    price_q  <= price_d;
    amt_q    <= amt_d;
    diff_q   <= diff_d;
    status_q <= status_d;
    paid_q   <= paid_d;
    unpaid_q <= unpaid_d;
  end

  // product memory: one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[cnt_q[IDX_W-1:0]] <= {item_q.product_code, item_q.price};
    end
    if (rd_en) begin
      rd_q <= mem_q[idx_q[IDX_W-1:0]];
    end
  end

  // checks
  `VSC_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(TABLE_DEPTH))
  `VSC_ASSERT_NXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)
  `VSC_ASSERT_IMP(a_one_at_a_time, out_valid_o, !in_ready_o)
  `VSC_ASSERT_IMP(a_banked_below_five, state_q == S_BANK1, amt_q < MONEY_W'(5))
  `VSC_ASSERT_IMP(a_paid_in_full, out_valid_o && (out_o.status == ST_PAID),
                  out_o.change_unpaid == '0)

endmodule

`default_nettype wire

FILE: rtl/vsc_coin_unit.sv
// vsc_coin_unit: shared coin step, banks or pays one denomination
// depends on vsc_pkg
`default_nettype none

module vsc_coin_unit (
  input  vsc_pkg::coin_op_t                 op_i,
  input  logic [vsc_pkg::MONEY_W-1:0]       amount_i,
  input  logic [vsc_pkg::COIN_W-1:0]        count_i,
  output logic [vsc_pkg::MONEY_W-1:0]       amount_o,
  output logic [vsc_pkg::COIN_W-1:0]        count_o
);
  import vsc_pkg::*;

  logic [PROD_W-1:0]  prod;
  logic [MONEY_W-1:0] quot;
  logic [MONEY_W-1:0] num;
  logic [COIN_W:0]    sum;
  logic [MONEY_W+2:0] value;

  assign prod = PROD_W'(amount_i) * PROD_W'(RECIP);

  always_comb begin
    case (op_i.denom)
      DEN_10:  quot = MONEY_W'(prod[PROD_W-1:11]);
      DEN_5:   quot = MONEY_W'(prod[PROD_W-1:10]);
      DEN_1:   quot = amount_i;
      default: quot = amount_i;
    endcase

    sum = {1'b0, count_i} + (COIN_W+1)'(quot);
    if (op_i.mode == MODE_BANK) begin
      // saturating bank
      num     = quot;
      count_o = sum[COIN_W] ? {COIN_W{1'b1}} : sum[COIN_W-1:0];
    end else begin
      // pay no more coins than held
      num     = (COIN_W'(quot) < count_i) ? quot : count_i[MONEY_W-1:0];
      count_o = count_i - COIN_W'(num);
    end

    case (op_i.denom)
      DEN_10:  value = {num, 3'b000} + {2'b00, num, 1'b0};
      DEN_5:   value = {num, 3'b000} - {1'b0, num, 2'b00} + {3'b000, num};
      DEN_1:   value = {3'b000, num};
      default: value = {3'b000, num};
    endcase
    amount_o = amount_i - value[MONEY_W-1:0];
  end

endmodule

`default_nettype wire
